// File: sv/gdds_pkg.sv
`default_nettype none
package gdds_pkg;

    localparam int NUM_PADS = 4;
    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 120;
    localparam int DZ_W       = 15;

    localparam logic [DZ_W-1:0] STICK_DZ_RST = 15'd3277;
    localparam logic [DZ_W-1:0] TRIG_DZ_RST  = 15'd3277;

    typedef enum logic {
        CFG_STICK_DZ = 1'b0,
        CFG_TRIG_DZ  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [DZ_W-1:0] stick_dz;
        logic [DZ_W-1:0] trig_dz;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] ry;
        logic signed [15:0] rx;
        logic signed [15:0] ly;
        logic signed [15:0] lx;
        logic [14:0]        rt;
        logic [14:0]        lt;
        logic [15:0]        buttons;
    } t_sample;

    typedef struct packed {
        logic       in_range;
        logic [1:0] idx;
        logic       idle;
        logic       frame_end;
        t_sample    smp;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

// File: sv/gdds_front.sv
`default_nettype none
module gdds_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [gdds_pkg::IN_DATA_W-1:0]    i_data,
    input  wire logic                              i_last,
    input  wire gdds_pkg::t_cfg                    i_cfg,
    input  wire gdds_pkg::t_q_status               i_q_status,
    output logic                                   o_push,
    output gdds_pkg::t_item                        o_item,
    output logic                                   o_busy
);
    import gdds_pkg::*;

    function automatic logic [16:0] mag16(input logic [15:0] v);
        logic [16:0] r;
        r = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        return r;
    endfunction

    logic          r_s1_valid;
    logic [1:0]    r_idx;
    logic          r_active;
    logic          r_last;
    t_sample       r_raw;
    logic [30:0]   r_lx_sq, r_ly_sq, r_rx_sq, r_ry_sq;
    logic [29:0]   r_sdz_sq;

    logic          advance;
    logic [33:0]   n_lx_p, n_ly_p, n_rx_p, n_ry_p;
    logic [16:0]   m_lx, m_ly, m_rx, m_ry;
    logic [31:0]   l_sum, r_sum;
    logic          l_zero, r_zero;
    logic          lt_low, rt_low;
    logic          axes_low_l, axes_low_r;
    logic [33:0]   n_sdz_p;
    t_sample       filt;

    assign advance = !r_s1_valid || !i_q_status.full;
    assign o_ready = advance;
    assign o_busy  = r_s1_valid;
    assign o_push  = r_s1_valid && !i_q_status.full;

    // squares of the incoming axis magnitudes, registered before the radius test
    always_comb begin
        n_lx_p  = {17'd0, mag16(i_data[64:49])} * {17'd0, mag16(i_data[64:49])};
        n_ly_p  = {17'd0, mag16(i_data[80:65])} * {17'd0, mag16(i_data[80:65])};
        n_rx_p  = {17'd0, mag16(i_data[96:81])} * {17'd0, mag16(i_data[96:81])};
        n_ry_p  = {17'd0, mag16(i_data[112:97])} * {17'd0, mag16(i_data[112:97])};
        n_sdz_p = {19'd0, i_cfg.stick_dz} * {19'd0, i_cfg.stick_dz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_sdz_sq   <= 30'(32'(STICK_DZ_RST) * 32'(STICK_DZ_RST));
        end else begin
            r_sdz_sq <= n_sdz_p[29:0];
            if (advance) begin
                r_s1_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_idx       <= i_data[1:0];
            r_active    <= i_data[2];
            r_last      <= i_last;
            r_raw.buttons <= i_data[18:3];
            r_raw.lt    <= i_data[33:19];
            r_raw.rt    <= i_data[48:34];
            r_raw.lx    <= i_data[64:49];
            r_raw.ly    <= i_data[80:65];
            r_raw.rx    <= i_data[96:81];
            r_raw.ry    <= i_data[112:97];
            r_lx_sq     <= n_lx_p[30:0];
            r_ly_sq     <= n_ly_p[30:0];
            r_rx_sq     <= n_rx_p[30:0];
            r_ry_sq     <= n_ry_p[30:0];
        end
    end

    always_comb begin
        m_lx   = mag16(r_raw.lx);
        m_ly   = mag16(r_raw.ly);
        m_rx   = mag16(r_raw.rx);
        m_ry   = mag16(r_raw.ry);
        l_sum  = {1'b0, r_lx_sq} + {1'b0, r_ly_sq};
        r_sum  = {1'b0, r_rx_sq} + {1'b0, r_ry_sq};
        l_zero = l_sum <= {2'b00, r_sdz_sq};
        r_zero = r_sum <= {2'b00, r_sdz_sq};
        lt_low = r_raw.lt < i_cfg.trig_dz;
        rt_low = r_raw.rt < i_cfg.trig_dz;

        filt         = r_raw;
        filt.lt      = lt_low ? 15'd0 : r_raw.lt;
        filt.rt      = rt_low ? 15'd0 : r_raw.rt;
        if (l_zero) begin
            filt.lx = '0;
            filt.ly = '0;
        end
        if (r_zero) begin
            filt.rx = '0;
            filt.ry = '0;
        end

        // a zeroed stick reads as magnitude zero, below any non-zero deadzone
        axes_low_l = l_zero ? (i_cfg.stick_dz != '0)
                            : (m_lx < {2'b00, i_cfg.stick_dz}) &&
                              (m_ly < {2'b00, i_cfg.stick_dz});
        axes_low_r = r_zero ? (i_cfg.stick_dz != '0)
                            : (m_rx < {2'b00, i_cfg.stick_dz}) &&
                              (m_ry < {2'b00, i_cfg.stick_dz});

        o_item.in_range  = 32'(r_idx) < NUM_PADS;
        o_item.idx       = r_idx;
        o_item.frame_end = r_last;
        o_item.idle      = !r_active ||
                           ((r_raw.buttons == '0) && lt_low && rt_low &&
                            axes_low_l && axes_low_r);
        o_item.smp       = filt;
    end

endmodule
`default_nettype wire

// File: sv/gdds_queue.sv
`default_nettype none
module gdds_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire gdds_pkg::t_item   i_item,
    input  wire logic              i_pop,
    output gdds_pkg::t_item        o_item,
    output gdds_pkg::t_q_status    o_status
);
    import gdds_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QAW:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.empty = r_count == '0;
    assign o_status.full  = r_count == (QAW+1)'(QDEPTH);

endmodule
`default_nettype wire

// File: sv/gdds_back.sv
`default_nettype none
module gdds_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire gdds_pkg::t_item                   i_item,
    input  wire gdds_pkg::t_q_status               i_q_status,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [gdds_pkg::OUT_DATA_W-1:0]        o_data
);
    import gdds_pkg::*;

    logic        r_owner_valid, n_owner_valid;
    logic [1:0]  r_owner_idx, n_owner_idx;
    logic        r_busy_seen, n_busy_seen;
    t_sample     r_own_s, n_own_s;
    logic        r_cand_found, n_cand_found;
    logic [1:0]  r_cand_idx, n_cand_idx;
    t_sample     r_cand_s, n_cand_s;
    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic        is_owner, fresh, keep, changed;
    t_sample     res_s;

    assign o_pop   = !i_q_status.empty &&
                     (!i_item.frame_end || !r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_comb begin
        n_owner_valid = r_owner_valid;
        n_owner_idx   = r_owner_idx;
        n_busy_seen   = r_busy_seen;
        n_own_s       = r_own_s;
        n_cand_found  = r_cand_found;
        n_cand_idx    = r_cand_idx;
        n_cand_s      = r_cand_s;
        is_owner      = i_item.idx == r_owner_idx;
        fresh         = !(r_owner_valid && is_owner);
        keep          = 1'b0;
        changed       = 1'b0;
        res_s         = r_own_s;
        n_out_data    = r_out_data;

        if (i_item.in_range) begin
            if (is_owner) begin
                n_own_s     = i_item.smp;
                n_busy_seen = !i_item.idle;
            end
            if (!i_item.idle && fresh && !r_cand_found) begin
                n_cand_found = 1'b1;
                n_cand_idx   = i_item.idx;
                n_cand_s     = i_item.smp;
            end
        end

        if (i_item.frame_end) begin
            keep  = r_owner_valid && n_busy_seen;
            res_s = n_own_s;
            if (!keep && n_cand_found) begin
                n_owner_idx   = n_cand_idx;
                n_owner_valid = 1'b1;
                res_s         = n_cand_s;
            end
            changed    = r_owner_valid && n_owner_valid && (r_owner_idx != n_owner_idx);
            n_out_data = {6'd0, res_s, changed, n_owner_valid, n_owner_idx};
            // per-frame tracking starts afresh
            n_busy_seen  = 1'b0;
            n_own_s      = '0;
            n_cand_found = 1'b0;
            n_cand_idx   = '0;
            n_cand_s     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_valid <= 1'b0;
            r_owner_idx   <= '0;
            r_busy_seen   <= 1'b0;
            r_own_s       <= '0;
            r_cand_found  <= 1'b0;
            r_cand_idx    <= '0;
            r_cand_s      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_owner_valid <= n_owner_valid;
                r_owner_idx   <= n_owner_idx;
                r_busy_seen   <= n_busy_seen;
                r_own_s       <= n_own_s;
                r_cand_found  <= n_cand_found;
                r_cand_idx    <= n_cand_idx;
                r_cand_s      <= n_cand_s;
            end
            if (o_pop && i_item.frame_end) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.frame_end) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

// File: sv/gamepad_deadzone_dominant_select.sv
`default_nettype none
// Gamepad deadzone filter with a sticky input owner. One pad sample is taken per
// cycle on the slave stream (tlast marks the frame's last pad) and one result
// transaction leaves on the master stream per frame. Each sample passes the axis
// square registers, then the radius and threshold tests into a four-entry queue,
// then the owner update into the output register. The queue and output register
// let the input keep running while a result waits; the input stalls only once
// the queue fills behind a result that i_m_tready has not taken. Deadzones are
// written on the config port (index 0 stick radius, index 1 trigger threshold),
// both Q0.15, reset 0.1.
module gamepad_deadzone_dominant_select (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // pad_index[1:0], pad_active[2], button_bits[18:3], left_trigger[33:19],
    // right_trigger[48:34], left_stick_x[64:49], left_stick_y[80:65],
    // right_stick_x[96:81], right_stick_y[112:97], zero fill above
    input  wire logic [gdds_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  wire logic                               i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // owner_index[1:0], owner_valid[2], owner_changed[3], out_buttons[19:4],
    // out_left_trigger[34:20], out_right_trigger[49:35], out_left_x[65:50],
    // out_left_y[81:66], out_right_x[97:82], out_right_y[113:98], zero fill above
    output logic [gdds_pkg::OUT_DATA_W-1:0]         o_m_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic                               i_cfg_index,
    input  wire logic [gdds_pkg::DZ_W-1:0]          i_cfg_data
);
    import gdds_pkg::*;

    t_cfg        r_cfg;
    t_item       push_item, pop_item;
    t_q_status   q_status;
    logic        push, pop, front_busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_dz <= STICK_DZ_RST;
            r_cfg.trig_dz  <= TRIG_DZ_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_STICK_DZ: r_cfg.stick_dz <= i_cfg_data;
                CFG_TRIG_DZ:  r_cfg.trig_dz  <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    gdds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_data     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item),
        .o_busy     (front_busy)
    );

    gdds_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (pop_item),
        .o_status (q_status)
    );

    gdds_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (pop_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (front_busy && q_status.full))
        else $error("input stalled while queue had room");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

    a_changed_needs_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3]) |-> o_m_tdata[2])
        else $error("owner change flagged without a valid owner");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");
`endif

endmodule
`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
    import gdds_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 160;

    // one pad sample as it travels on the slave stream (frame_end goes on tlast)
    typedef struct packed {
        logic       fend;
        t_sample    smp;
        logic       active;
        logic [1:0] idx;
    } t_pad;

    // one frame report as it leaves on the master stream
    typedef struct packed {
        t_sample    smp;
        logic       changed;
        logic       valid;
        logic [1:0] owner;
    } t_owner_report;

    typedef struct packed {
        logic          cfg_set;
        logic [14:0]   stick;
        logic [14:0]   trig;
        t_pad          pad;
        logic          has_want;
        t_owner_report want;
    } t_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_index            cfg_index = CFG_STICK_DZ;
    logic [DZ_W-1:0]       cfg_data = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   cfg_ready;

    gamepad_deadzone_dominant_select dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [14:0]   stick_dz = STICK_DZ_RST;
    logic [14:0]   trig_dz = TRIG_DZ_RST;
    logic [1:0]    cur_owner = '0;
    logic          owner_live = 1'b0;
    logic          owner_busy = 1'b0;
    t_sample       owner_smp = '0;
    logic          cand_hit = 1'b0;
    logic [1:0]    cand_owner = '0;
    t_sample       cand_smp = '0;

    t_owner_report reports_due[$];
    int            errors = 0;
    int            cycle_count = 0;
    int            tx_calm = 0;
    int            rx_calm = 0;
    int            rx_hold = 0;
    int            rx_pick;
    t_owner_report mon_got;
    t_owner_report mon_want;

    function automatic int axis_mag(logic signed [15:0] v);
        return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function automatic bit stick_in_deadzone(logic signed [15:0] x, logic signed [15:0] y);
        longint ax;
        longint ay;
        ax = axis_mag(x);
        ay = axis_mag(y);
        return (ax * ax + ay * ay) <= longint'(stick_dz) * longint'(stick_dz);
    endfunction

    function automatic bit predict_owner_report(input t_pad p, output t_owner_report r);
        t_sample f;
        bit      idle;
        bit      fresh;
        bit      prev_live;
        logic [1:0] prev_owner;
        t_sample out_smp;
        r = '0;
        if (int'(p.idx) < NUM_PADS) begin
            f = p.smp;
            if (f.lt < trig_dz) f.lt = '0;
            if (f.rt < trig_dz) f.rt = '0;
            if (stick_in_deadzone(f.lx, f.ly)) begin
                f.lx = '0;
                f.ly = '0;
            end
            if (stick_in_deadzone(f.rx, f.ry)) begin
                f.rx = '0;
                f.ry = '0;
            end
            idle = f.buttons == 0 && f.lt < trig_dz && f.rt < trig_dz &&
                   axis_mag(f.lx) < int'(stick_dz) && axis_mag(f.ly) < int'(stick_dz) &&
                   axis_mag(f.rx) < int'(stick_dz) && axis_mag(f.ry) < int'(stick_dz);
            idle = idle || !p.active;
            // a later sample for the owner overwrites the earlier one
            if (p.idx == cur_owner) begin
                owner_smp = f;
                owner_busy = !idle;
            end
            fresh = !(owner_live && p.idx == cur_owner);
            if (!idle && fresh && !cand_hit) begin
                cand_hit = 1'b1;
                cand_owner = p.idx;
                cand_smp = f;
            end
        end
        if (!p.fend) return 1'b0;
        prev_live = owner_live;
        prev_owner = cur_owner;
        out_smp = owner_smp;
        if (!(owner_live && owner_busy) && cand_hit) begin
            cur_owner = cand_owner;
            owner_live = 1'b1;
            out_smp = cand_smp;
        end
        r.owner = cur_owner;
        r.valid = owner_live;
        r.changed = prev_live && owner_live && prev_owner != cur_owner;
        r.smp = out_smp;
        owner_busy = 1'b0;
        owner_smp = '0;
        cand_hit = 1'b0;
        cand_owner = '0;
        cand_smp = '0;
        return 1'b1;
    endfunction

    // mostly short pauses, a few long ones, and calm stretches with none
    task automatic pick_pause(inout int calm, output int n);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm = calm - 1;
            n = 0;
        end else if (r < 2) begin
            calm = $urandom_range(20, 80);
            n = 0;
        end else if (r < 60) begin
            n = 0;
        end else if (r < 90) begin
            n = $urandom_range(1, 3);
        end else if (r < 97) begin
            n = $urandom_range(4, 12);
        end else begin
            n = $urandom_range(20, 40);
        end
    endtask

    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            pick_pause(rx_calm, rx_pick);
            rx_hold <= rx_pick;
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            mon_got = m_tdata[113:0];
            if (reports_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: owner=%0d valid=%b changed=%b btn=%h",
                             mon_got.owner, mon_got.valid, mon_got.changed,
                             mon_got.smp.buttons);
            end else begin
                mon_want = reports_due.pop_front();
                if (mon_got.owner !== mon_want.owner || mon_got.valid !== mon_want.valid ||
                    mon_got.changed !== mon_want.changed ||
                    mon_got.smp.buttons !== mon_want.smp.buttons ||
                    mon_got.smp.lt !== mon_want.smp.lt || mon_got.smp.rt !== mon_want.smp.rt ||
                    mon_got.smp.lx !== mon_want.smp.lx || mon_got.smp.ly !== mon_want.smp.ly ||
                    mon_got.smp.rx !== mon_want.smp.rx || mon_got.smp.ry !== mon_want.smp.ry)
                begin
                    errors++;
                    if (errors <= 10) begin
                        $display("report mismatch, expected: owner=%0d valid=%b changed=%b btn=%h lt=%h rt=%h lx=%h ly=%h rx=%h ry=%h",
                                 mon_want.owner, mon_want.valid, mon_want.changed,
                                 mon_want.smp.buttons, mon_want.smp.lt, mon_want.smp.rt,
                                 mon_want.smp.lx, mon_want.smp.ly, mon_want.smp.rx,
                                 mon_want.smp.ry);
                        $display("                 actual:   owner=%0d valid=%b changed=%b btn=%h lt=%h rt=%h lx=%h ly=%h rx=%h ry=%h",
                                 mon_got.owner, mon_got.valid, mon_got.changed,
                                 mon_got.smp.buttons, mon_got.smp.lt, mon_got.smp.rt,
                                 mon_got.smp.lx, mon_got.smp.ly, mon_got.smp.rx,
                                 mon_got.smp.ry);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_pad(input t_pad p, input bit typed, input t_owner_report typed_rep);
        int            gap;
        t_owner_report r;
        pick_pause(tx_calm, gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, p.smp, p.active, p.idx};
        s_tlast <= p.fend;
        do @(posedge clk); while (!s_tready);
        if (predict_owner_report(p, r))
            reports_due.push_back(typed ? typed_rep : r);
    endtask

    // deadzones change only with the block drained
    task automatic write_deadzones(input logic [14:0] stick, input logic [14:0] trig);
        bit trig_first;
        bit as_trig;
        trig_first = $urandom_range(0, 1);
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int k = 0; k < 2; k++) begin
            as_trig = (k == 0) ? trig_first : !trig_first;
            cfg_valid <= 1'b1;
            cfg_index <= as_trig ? CFG_TRIG_DZ : CFG_STICK_DZ;
            cfg_data <= as_trig ? trig : stick;
            do @(posedge clk); while (!cfg_ready);
            if (as_trig) trig_dz = trig;
            else stick_dz = stick;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [14:0] pick_trig(bit quiet);
        if (quiet) return (trig_dz == 0) ? 15'd0 : 15'($urandom_range(0, int'(trig_dz) - 1));
        case ($urandom_range(0, 5))
            0: return 15'd0;
            1: return trig_dz - 15'd1;
            2: return trig_dz;
            3: return 15'h7FFF;
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_axis(bit quiet);
        int lim;
        lim = int'(stick_dz) - 1;
        if (quiet) return (stick_dz == 0) ? 16'd0 : 16'($urandom_range(0, 2 * lim) - lim);
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'(stick_dz);
            2: return 16'(-int'(stick_dz));
            3: return 16'h8000;
            4: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_sample smp_of(logic [15:0] btn, logic [14:0] lt, logic [14:0] rt,
                                       logic [15:0] lx, logic [15:0] ly,
                                       logic [15:0] rx, logic [15:0] ry);
        t_sample s;
        s.buttons = btn;
        s.lt = lt;
        s.rt = rt;
        s.lx = lx;
        s.ly = ly;
        s.rx = rx;
        s.ry = ry;
        return s;
    endfunction

    function automatic t_sample rand_sample(bit quiet);
        logic [15:0] btn;
        btn = (quiet || $urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        return smp_of(btn, pick_trig(quiet), pick_trig(quiet), pick_axis(quiet),
                      pick_axis(quiet), pick_axis(quiet), pick_axis(quiet));
    endfunction

    function automatic t_row pad_row(logic [1:0] idx, logic act, t_sample s, logic fend);
        t_row r;
        r = '0;
        r.pad.idx = idx;
        r.pad.active = act;
        r.pad.smp = s;
        r.pad.fend = fend;
        return r;
    endfunction

    // mostly ascending frames, with descending, repeated-index and scrambled ones mixed in
    task automatic run_frame(output int n);
        logic [1:0]    order[$];
        int            kind;
        int            dup;
        int            pos;
        t_pad          p;
        t_owner_report none;
        kind = $urandom_range(0, 9);
        dup = $urandom_range(0, 3);
        none = '0;
        if (kind == 9) begin
            repeat ($urandom_range(1, 5)) order.push_back(2'($urandom_range(0, 3)));
        end else begin
            for (int i = 0; i < 4; i++) begin
                pos = (kind == 7) ? 3 - i : i;
                if ($urandom_range(0, 3) != 0) begin
                    order.push_back(2'(pos));
                    if (kind == 8 && pos == dup) order.push_back(2'(pos));
                end
            end
            if (order.size() == 0) order.push_back(2'(dup));
        end
        n = order.size();
        foreach (order[k]) begin
            p.idx = order[k];
            p.active = ($urandom_range(0, 7) != 0);
            p.smp = rand_sample($urandom_range(0, 1));
            p.fend = (k == n - 1);
            send_pad(p, 1'b0, none);
        end
    endtask

    initial begin
        t_row stim_rows[$];
        t_row r;
        t_sample zero_smp;
        int sent;
        int n;

        zero_smp = '0;

        // after reset: inactive pad 0 alone, nobody owns yet
        r = pad_row(2'd0, 1'b0, zero_smp, 1'b1);
        r.has_want = 1'b1;
        stim_rows.push_back(r);
        // pad 0 presses a button and takes ownership
        r = pad_row(2'd0, 1'b1, smp_of(16'h0001, 0, 0, 0, 0, 0, 0), 1'b1);
        r.has_want = 1'b1;
        r.want.valid = 1'b1;
        r.want.smp = smp_of(16'h0001, 0, 0, 0, 0, 0, 0);
        stim_rows.push_back(r);
        // full-scale values pass untouched
        r = pad_row(2'd0, 1'b1, smp_of(16'hFFFF, 15'h7FFF, 15'h7FFF, 16'h8000, 16'h7FFF,
                                       16'h8000, 16'h8000), 1'b1);
        r.has_want = 1'b1;
        r.want.valid = 1'b1;
        r.want.smp = r.pad.smp;
        stim_rows.push_back(r);
        // trigger just under and at threshold, sticks inside and on the radius
        stim_rows.push_back(pad_row(2'd0, 1'b1, smp_of(0, 15'd3276, 15'd3277, 16'd100,
                                                       -16'sd100, 16'd3277, 0), 1'b1));
        // idle owner hands over to the first busy pad
        stim_rows.push_back(pad_row(2'd0, 1'b1, zero_smp, 1'b0));
        stim_rows.push_back(pad_row(2'd1, 1'b1, smp_of(16'h0002, 0, 0, 0, 0, 0, 0), 1'b0));
        stim_rows.push_back(pad_row(2'd2, 1'b1, smp_of(16'h0004, 0, 0, 0, 0, 0, 0), 1'b1));
        // owner missing from the frame keeps ownership with an all-zero sample
        stim_rows.push_back(pad_row(2'd2, 1'b0, smp_of(16'hA5A5, 0, 0, 0, 0, 0, 0), 1'b0));
        r = pad_row(2'd3, 1'b0, zero_smp, 1'b1);
        r.has_want = 1'b1;
        r.want.owner = 2'd1;
        r.want.valid = 1'b1;
        stim_rows.push_back(r);
        // repeated owner index, the later sample counts
        stim_rows.push_back(pad_row(2'd1, 1'b1, smp_of(16'h0008, 0, 0, 0, 0, 0, 0), 1'b0));
        stim_rows.push_back(pad_row(2'd1, 1'b1, zero_smp, 1'b1));
        // descending order, first arrival wins
        stim_rows.push_back(pad_row(2'd3, 1'b1, smp_of(16'h0010, 0, 0, 0, 0, 0, 0), 1'b0));
        stim_rows.push_back(pad_row(2'd2, 1'b1, smp_of(16'h0020, 0, 0, 0, 0, 0, 0), 1'b0));
        stim_rows.push_back(pad_row(2'd1, 1'b0, zero_smp, 1'b1));
        // stick just outside the radius
        stim_rows.push_back(pad_row(2'd3, 1'b1, smp_of(0, 0, 0, 16'd3277, 16'd1, 0, 0), 1'b1));
        // zero deadzones: an all-zero pad is busy
        r = pad_row(2'd0, 1'b1, zero_smp, 1'b1);
        r.cfg_set = 1'b1;
        stim_rows.push_back(r);
        stim_rows.push_back(pad_row(2'd3, 1'b1, zero_smp, 1'b1));
        // largest deadzones
        r = pad_row(2'd3, 1'b1, smp_of(0, 15'h7FFF, 15'h7FFE, 16'h8000, 0, 16'd23170,
                                       16'd23170), 1'b1);
        r.cfg_set = 1'b1;
        r.stick = 15'h7FFF;
        r.trig = 15'h7FFF;
        stim_rows.push_back(r);
        stim_rows.push_back(pad_row(2'd0, 1'b1, smp_of(16'h8000, 0, 0, 0, 0, 0, 0), 1'b0));
        stim_rows.push_back(pad_row(2'd3, 1'b1, smp_of(0, 15'h7FFE, 15'h7FFE, 16'h7FFF, 0,
                                                       0, 16'h8001), 1'b1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[k]) begin
            if (stim_rows[k].cfg_set) write_deadzones(stim_rows[k].stick, stim_rows[k].trig);
            send_pad(stim_rows[k].pad, stim_rows[k].has_want, stim_rows[k].want);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_deadzones(15'd0, 15'd0);
                1: write_deadzones(15'h7FFF, 15'h7FFF);
                2: write_deadzones(STICK_DZ_RST, TRIG_DZ_RST);
                3: write_deadzones(15'($urandom_range(0, 8000)), 15'($urandom_range(0, 8000)));
                default: write_deadzones(15'($urandom), 15'($urandom));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                run_frame(n);
                sent += n;
            end
        end

        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
sv/gdds_pkg.sv
sv/gdds_front.sv
sv/gdds_queue.sv
sv/gdds_back.sv
sv/gamepad_deadzone_dominant_select.sv
verif/tb_top.sv
